// ===== hw/rtl/rso_pkg.sv =====
// Shared types and constants of the recursive sine oscillator.
// Holds the controller/datapath command and status structs and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package rso_pkg;

  // Fixed-point formats of the oscillator state.
  localparam int VALUE_BITS = 24;
  localparam int FRAC_BITS  = 22;
  localparam int GAIN_BITS  = 16;
  localparam int GAIN_ACC_BITS = 32;
  localparam int CHAN_BITS  = 4;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CHANNEL_FIELD_BITS = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_P       = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_VALUE  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_LEVEL = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNELS     = 3'd3;

  // Reset value of the channel count register.
  localparam logic [CHAN_BITS-1:0] CHANNELS_RESET = 4'd2;

  typedef struct packed {
    logic start;       // frame request accepted, apply pending reload
    logic mul;         // form coefficient times newer value
    logic upd;         // close the recursion and form value times gain
    logic scl;         // saturate sample, glide gain, clear channel count
    logic emit_next;   // current channel copy taken
  } rso_cmd_t;

  typedef struct packed {
    logic last;        // current channel copy is the final one
  } rso_status_t;

endpackage

// ===== hw/rtl/rso_datapath.sv =====
// Datapath of the recursive sine oscillator: config registers, recursion,
// gain multiply and smoothing, and the channel copy counter. Uses rso_pkg.
`timescale 1ns / 1ps

module rso_datapath import rso_pkg::*; #(
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 24,
  parameter int SMOOTH_SHIFT = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  rso_cmd_t                      cmd,
  output rso_status_t                   status,
  output logic signed [SAMPLE_BITS-1:0] sample,
  output logic [CHANNEL_FIELD_BITS-1:0] channel,
  output logic                          last_channel
);

  localparam int CNT_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_XW = (CNT_W > CHANNEL_FIELD_BITS) ? CNT_W : CHANNEL_FIELD_BITS;
  localparam int NUM_W  = CNT_W + 1;
  localparam int PROD_W = 2 * VALUE_BITS;
  localparam int QX_W   = PROD_W - FRAC_BITS + 1;
  localparam int SPROD_W = VALUE_BITS + GAIN_BITS + 1;
  localparam int SSH_W  = SPROD_W - GAIN_BITS;
  localparam int SEXT_W = ((SSH_W > SAMPLE_BITS) ? SSH_W : SAMPLE_BITS) + 1;
  localparam int DIFF_W = GAIN_ACC_BITS + 1;

  logic signed [VALUE_BITS-1:0]    coef_p;
  logic signed [VALUE_BITS-1:0]    start_value;
  logic [GAIN_BITS-1:0]            target_level;
  logic [CHAN_BITS-1:0]            channels;
  logic signed [VALUE_BITS-1:0]    older_value;
  logic signed [VALUE_BITS-1:0]    newer_value;
  logic [GAIN_ACC_BITS-1:0]        gain_level;
  logic                            reload_pending;
  logic signed [PROD_W-1:0]        prod_q;
  logic signed [SPROD_W-1:0]       prod_s;
  logic signed [SAMPLE_BITS-1:0]   sample_q;
  logic [CNT_W-1:0]                cnt;

  logic signed [QX_W-1:0]          q_wide;
  logic signed [VALUE_BITS-1:0]    q_sat;
  logic signed [SEXT_W-1:0]        s_ext;
  logic signed [SEXT_W-1:0]        s_hi;
  logic signed [SEXT_W-1:0]        s_lo;
  logic signed [SAMPLE_BITS-1:0]   s_sat;
  logic signed [DIFF_W-1:0]        gain_diff;
  logic signed [DIFF_W-1:0]        gain_step;
  logic [NUM_W-1:0]                num_eff;
  logic [NUM_W-1:0]                cnt_plus;
  logic [CNT_XW-1:0]               cnt_ext;

  // Recursion: floor(p*q1 / 2^22) - q0, saturated to the state width.
  always_comb begin
    q_wide = QX_W'(prod_q >>> FRAC_BITS) - QX_W'(older_value);
    if (q_wide > QX_W'((1 <<< (VALUE_BITS - 1)) - 1)) begin
      q_sat = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end else if (q_wide < -QX_W'(1 <<< (VALUE_BITS - 1))) begin
      q_sat = {1'b1, {(VALUE_BITS-1){1'b0}}};
    end else begin
      q_sat = q_wide[VALUE_BITS-1:0];
    end
  end

  // Sample: floor(q * gain / 2^16), saturated to the sample width.
  always_comb begin
    s_ext = SEXT_W'(prod_s >>> GAIN_BITS);
    s_hi  = {{(SEXT_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    s_lo  = ~s_hi;
    if (s_ext > s_hi) begin
      s_sat = s_hi[SAMPLE_BITS-1:0];
    end else if (s_ext < s_lo) begin
      s_sat = s_lo[SAMPLE_BITS-1:0];
    end else begin
      s_sat = s_ext[SAMPLE_BITS-1:0];
    end
  end

  // Gain glides a fixed fraction of the remaining distance, rounded down.
  always_comb begin
    gain_diff = $signed({1'b0, target_level, {(GAIN_ACC_BITS-GAIN_BITS){1'b0}}})
              - $signed({1'b0, gain_level});
    gain_step = gain_diff >>> SMOOTH_SHIFT;
  end

  always_comb begin
    if (channels == '0) begin
      num_eff = NUM_W'(1);
    end else if ({1'b0, channels} > 5'(MAX_CHANNELS)) begin
      num_eff = NUM_W'(MAX_CHANNELS);
    end else begin
      num_eff = NUM_W'(channels);
    end
    cnt_plus = NUM_W'(cnt) + NUM_W'(1);
    cnt_ext  = CNT_XW'(cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_p         <= '0;
      start_value    <= '0;
      target_level   <= '0;
      channels       <= CHANNELS_RESET;
      older_value    <= '0;
      newer_value    <= '0;
      gain_level     <= '0;
      reload_pending <= 1'b1;
      cnt            <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COEF_P: begin
            coef_p         <= cfg_data[VALUE_BITS-1:0];
            reload_pending <= 1'b1;
          end
          REG_START_VALUE: begin
            start_value    <= cfg_data[VALUE_BITS-1:0];
            reload_pending <= 1'b1;
          end
          REG_TARGET_LEVEL: target_level <= cfg_data[GAIN_BITS-1:0];
          REG_CHANNELS:     channels     <= cfg_data[CHAN_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.start && reload_pending) begin
        reload_pending <= 1'b0;
        newer_value    <= '0;
        older_value    <= start_value;
      end
      if (cmd.upd) begin
        older_value <= newer_value;
        newer_value <= q_sat;
      end
      if (cmd.scl) begin
        gain_level <= gain_level + gain_step[GAIN_ACC_BITS-1:0];
        cnt        <= '0;
      end
      if (cmd.emit_next) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // Product registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_q <= coef_p * newer_value;
    end
    if (cmd.upd) begin
      prod_s <= q_sat * $signed({1'b0, gain_level[GAIN_ACC_BITS-1 -: GAIN_BITS]});
    end
    if (cmd.scl) begin
      sample_q <= s_sat;
    end
  end

  assign status.last  = (cnt_plus == num_eff);
  assign sample       = sample_q;
  assign channel      = cnt_ext[CHANNEL_FIELD_BITS-1:0];
  assign last_channel = status.last;

endmodule

// ===== hw/rtl/rso_controller.sv =====
// Frame sequencer of the recursive sine oscillator.
// Drives the datapath through rso_pkg command and status structs.
`timescale 1ns / 1ps

module rso_controller import rso_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        tick,
  output logic        out_valid,
  input  logic        out_ready,
  input  rso_status_t status,
  output rso_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_SCL  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    in_ready      = (state == S_IDLE);
    out_valid     = (state == S_EMIT);
    cmd.start     = in_ready && in_valid && tick;
    cmd.mul       = (state == S_MUL);
    cmd.upd       = (state == S_UPD);
    cmd.scl       = (state == S_SCL);
    cmd.emit_next = out_valid && out_ready;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd.start) state_next = S_MUL;
      S_MUL:  state_next = S_UPD;
      S_UPD:  state_next = S_SCL;
      S_SCL:  state_next = S_EMIT;
      S_EMIT: if (cmd.emit_next && status.last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_start_steps: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> cmd.mul ##1 cmd.upd ##1 cmd.scl ##1 out_valid)
    else $error("frame did not walk through the arithmetic steps");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_next && status.last) |=> in_ready && !out_valid)
    else $error("block not idle after final channel copy");

  a_copy_more: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_next && !status.last) |=> out_valid)
    else $error("channel copies stopped before the final one");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.mul, cmd.upd, cmd.scl, out_valid, in_ready}))
    else $error("more than one sequencer step active");

endmodule

// ===== hw/rtl/recursive_sine_oscillator.sv =====
// Top level of the recursive sine oscillator: configuration port, sequencer
// and datapath. Depends on rso_pkg, rso_controller and rso_datapath.
`timescale 1ns / 1ps

// Each accepted request with tick high advances a second-order recursion
// q_new = p*q1 - q0 (signed Q2.22), scales the new value by a smoothed gain
// and sends the saturated sample once per configured channel, the final copy
// flagged by last_channel. A request with tick low is taken and produces
// nothing. A frame steps from acceptance through the coefficient multiplier,
// closing the recursion and driving the gain multiplier, saturating the
// sample and gliding the gain, then the n channel copies at the output
// register, where n is the effective channel count (1 to MAX_CHANNELS), each
// held until the output side takes it. Requests are held off while copies
// are still waiting. Writing the coefficient or the start value restarts the
// oscillator at the next frame (q1 = 0, q0 = start value); writing the target
// lets the gain keep gliding toward it by 1/2^SMOOTH_SHIFT of the remaining
// distance per frame. The configuration port is always ready and must only be
// written while no frame is in flight.

module recursive_sine_oscillator import rso_pkg::*; #(
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 24,
  parameter int SMOOTH_SHIFT = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          tick,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample,
  output logic [CHANNEL_FIELD_BITS-1:0] channel,
  output logic                          last_channel,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

  rso_cmd_t    cmd;
  rso_status_t status;

  // Register writes complete in the cycle they are offered.
  assign cfg_ready = 1'b1;

  rso_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .tick      (tick),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rso_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .SMOOTH_SHIFT (SMOOTH_SHIFT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .sample       (sample),
    .channel      (channel),
    .last_channel (last_channel)
  );

endmodule
